### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

### rtl/nec_ir_pkg.sv
// Shared types and constants of the NEC IR edge decoder.
`default_nettype none
package nec_ir_pkg;

   // Width of the timer that stamps the edges (16 to 32).
   localparam int TICK_BITS = 32;
   localparam int EDGE_BITS = 32;
   // Compare width: durations against upper window bounds (17 bits).
   localparam int HI_BITS   = 17;
   localparam int CMP_BITS  = (TICK_BITS > HI_BITS) ? TICK_BITS : HI_BITS;

   localparam int CFG_COUNT = 6;
   localparam int ADDR_BITS = 5;
   localparam int IDX_BITS  = 3;

   typedef enum logic [IDX_BITS-1:0] {
      REG_LEADER_MARK  = 3'd0,
      REG_LEADER_SPACE = 3'd1,
      REG_REPEAT_SPACE = 3'd2,
      REG_BIT_MARK     = 3'd3,
      REG_ZERO_SPACE   = 3'd4,
      REG_ONE_SPACE    = 3'd5
   } cfg_index_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_LMARK  = 2'd1,
      PH_LSPACE = 2'd2,
      PH_DATA   = 2'd3
   } phase_type;

   localparam logic [1:0] ST_NEW     = 2'd0;
   localparam logic [1:0] ST_REPEAT  = 2'd1;
   localparam logic [1:0] ST_BIT_ERR = 2'd2;
   localparam logic [1:0] ST_INV_ERR = 2'd3;

   // Tolerance divisors: leader checks +-1/10, bit checks +-1/5.
   localparam int DIV_LEADER = 10;
   localparam int DIV_BIT    = 5;

   // x/10 = (x*0xCCCD) >> 19 and x/5 = (x*0xCCCD) >> 18, exact for 16-bit x.
   localparam logic [15:0] RECIP       = 16'hCCCD;
   localparam int          SHIFT_TENTH = 19;
   localparam int          SHIFT_FIFTH = 18;

   localparam int RST_LEADER_MARK  = 900;
   localparam int RST_LEADER_SPACE = 450;
   localparam int RST_REPEAT_SPACE = 225;
   localparam int RST_BIT_MARK     = 56;
   localparam int RST_ZERO_SPACE   = 56;
   localparam int RST_ONE_SPACE    = 169;

   localparam logic [15:0] CFG_RESET [CFG_COUNT] = '{
      16'(RST_LEADER_MARK), 16'(RST_LEADER_SPACE), 16'(RST_REPEAT_SPACE),
      16'(RST_BIT_MARK), 16'(RST_ZERO_SPACE), 16'(RST_ONE_SPACE)
   };

   localparam logic [15:0] CFG_MARGIN [CFG_COUNT] = '{
      16'(RST_LEADER_MARK / DIV_LEADER), 16'(RST_LEADER_SPACE / DIV_LEADER),
      16'(RST_REPEAT_SPACE / DIV_LEADER), 16'(RST_BIT_MARK / DIV_BIT),
      16'(RST_ZERO_SPACE / DIV_BIT), 16'(RST_ONE_SPACE / DIV_BIT)
   };

endpackage
`default_nettype wire

### rtl/nec_ir_edge_decoder_core.sv
// NEC IR edge decoder: leader, repeat and 32-bit frame decode from edge stamps.
// A result is registered on rsp_* in the cycle after the edge that completes it.
// Throughput: one edge per cycle when no result stalls; the duration subtract
//   and six window compares sit between request port and state/result registers.
// Reset (synchronous, active high): phase idle, previous tick, frame and last
//   command cleared, registers back to their nominal values, no result held.
`default_nettype none
module nec_ir_edge_decoder_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // edge channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [nec_ir_pkg::EDGE_BITS-1:0]  req_edge_tick,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic [7:0]                             rsp_command,
   // register port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [nec_ir_pkg::ADDR_BITS-1:0]  paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);
   import nec_ir_pkg::*;

   // ------------------------------------------------------------------
   // Register file. Each register keeps its nominal value plus the low and
   // high bounds of its window, worked out once when the register is
   // written, so the edge path only compares.
   // ------------------------------------------------------------------
   logic [15:0]        nom_ff [CFG_COUNT];
   logic [15:0]        lo_ff  [CFG_COUNT];
   logic [HI_BITS-1:0] hi_ff  [CFG_COUNT];

   logic [IDX_BITS-1:0] csr_idx;
   logic                csr_wr;
   logic [15:0]         csr_val;
   logic [31:0]         csr_prod;
   logic [15:0]         csr_margin;

   assign pready  = 1'b1;
   assign csr_idx = paddr[ADDR_BITS-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_val = pwdata[15:0];

   // one shared reciprocal multiply; leader registers take 1/10, bit ones 1/5
   assign csr_prod   = 32'(csr_val) * 32'(RECIP);
   assign csr_margin = (csr_idx < REG_BIT_MARK) ? 16'(csr_prod >> SHIFT_TENTH)
                                                : 16'(csr_prod >> SHIFT_FIFTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_COUNT; i++) begin
            nom_ff[i] <= CFG_RESET[i];
            lo_ff[i]  <= CFG_RESET[i] - CFG_MARGIN[i];
            hi_ff[i]  <= HI_BITS'(CFG_RESET[i]) + HI_BITS'(CFG_MARGIN[i]);
         end
      end else if (csr_wr && (csr_idx < IDX_BITS'(CFG_COUNT))) begin
         nom_ff[csr_idx] <= csr_val;
         lo_ff[csr_idx]  <= csr_val - csr_margin;
         hi_ff[csr_idx]  <= HI_BITS'(csr_val) + HI_BITS'(csr_margin);
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (csr_idx < IDX_BITS'(CFG_COUNT)) begin
         prdata = {16'd0, nom_ff[csr_idx]};
      end
   end

   // ------------------------------------------------------------------
   // Decoder state
   // ------------------------------------------------------------------
   phase_type            phase_ff, phase_in;
   logic [TICK_BITS-1:0] prev_tick_ff, prev_tick_in;
   logic [4:0]           bit_count_ff, bit_count_in;
   logic                 second_half_ff, second_half_in;
   logic                 mark_ok_ff, mark_ok_in;
   logic [31:0]          frame_ff, frame_in;
   logic [7:0]           last_cmd_ff, last_cmd_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [7:0]           rsp_command_ff, rsp_command_in;

   logic                 req_xfer;
   logic [TICK_BITS-1:0] now_tick;
   logic [TICK_BITS-1:0] dur;
   logic [CFG_COUNT-1:0] win;

   // output register empties or drains this cycle: take the next edge
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign now_tick = req_edge_tick[TICK_BITS-1:0];
   assign dur      = now_tick - prev_tick_ff;   // wraps modulo the timer width

   always_comb begin
      for (int i = 0; i < CFG_COUNT; i++) begin
         win[i] = (CMP_BITS'(dur) >= CMP_BITS'(lo_ff[i])) &&
                  (CMP_BITS'(dur) <= CMP_BITS'(hi_ff[i]));
      end
   end

   // data-phase bit decision, shared by both state blocks
   logic        bit_err;
   logic        bit_val;
   logic [31:0] frame_bit;
   logic        frame_last;
   logic        inv_ok;

   always_comb begin
      bit_err = 1'b0;
      bit_val = 1'b0;
      if (!mark_ok_ff) begin
         bit_err = 1'b1;
      end else if (win[REG_ZERO_SPACE]) begin
         bit_val = 1'b0;             // zero window wins when both match
      end else if (win[REG_ONE_SPACE]) begin
         bit_val = 1'b1;
      end else begin
         bit_err = 1'b1;
      end
      frame_bit          = frame_ff;
      frame_bit[bit_count_ff] = bit_val;
      frame_last = (bit_count_ff == 5'd31);
      inv_ok     = (frame_bit[7:0] == ~frame_bit[15:8]) &&
                   (frame_bit[23:16] == ~frame_bit[31:24]);
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (req_xfer) begin
         case (phase_ff)
            PH_IDLE:   phase_in = PH_LMARK;
            PH_LMARK:  phase_in = win[REG_LEADER_MARK] ? PH_LSPACE : PH_IDLE;
            PH_LSPACE: phase_in = win[REG_LEADER_SPACE] ? PH_DATA : PH_IDLE;
            PH_DATA: begin
               if (second_half_ff && (bit_err || frame_last)) begin
                  phase_in = PH_IDLE;
               end
            end
            default:   phase_in = PH_IDLE;
         endcase
      end
   end

   // datapath state and result
   always_comb begin
      prev_tick_in   = prev_tick_ff;
      bit_count_in   = bit_count_ff;
      second_half_in = second_half_ff;
      mark_ok_in     = mark_ok_ff;
      frame_in       = frame_ff;
      last_cmd_in    = last_cmd_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_command_in = rsp_command_ff;
      if (req_xfer) begin
         prev_tick_in = now_tick;
         case (phase_ff)
            PH_LSPACE: begin
               bit_count_in   = 5'd0;
               second_half_in = 1'b0;
               mark_ok_in     = 1'b0;
               frame_in       = 32'd0;
               if (!win[REG_LEADER_SPACE] && win[REG_REPEAT_SPACE]) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = ST_REPEAT;
                  rsp_command_in = last_cmd_ff;
               end
            end
            PH_DATA: begin
               if (!second_half_ff) begin
                  mark_ok_in     = win[REG_BIT_MARK];
                  second_half_in = 1'b1;
               end else if (bit_err || frame_last) begin
                  // frame ends: back to idle with a cleared frame
                  bit_count_in   = 5'd0;
                  second_half_in = 1'b0;
                  mark_ok_in     = 1'b0;
                  frame_in       = 32'd0;
                  rsp_valid_in   = 1'b1;
                  rsp_command_in = 8'd0;
                  if (bit_err) begin
                     rsp_status_in = ST_BIT_ERR;
                  end else if (!inv_ok) begin
                     rsp_status_in = ST_INV_ERR;
                  end else begin
                     rsp_status_in  = ST_NEW;
                     rsp_command_in = frame_bit[23:16];
                     last_cmd_in    = frame_bit[23:16];
                  end
               end else begin
                  second_half_in = 1'b0;
                  frame_in       = frame_bit;
                  bit_count_in   = bit_count_ff + 5'd1;
               end
            end
            default: begin
               // idle and leader mark leave the bit state clear
               bit_count_in   = 5'd0;
               second_half_in = 1'b0;
               mark_ok_in     = 1'b0;
               frame_in       = 32'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         prev_tick_ff   <= '0;
         bit_count_ff   <= 5'd0;
         second_half_ff <= 1'b0;
         mark_ok_ff     <= 1'b0;
         frame_ff       <= 32'd0;
         last_cmd_ff    <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         prev_tick_ff   <= prev_tick_in;
         bit_count_ff   <= bit_count_in;
         second_half_ff <= second_half_in;
         mark_ok_ff     <= mark_ok_in;
         frame_ff       <= frame_in;
         last_cmd_ff    <= last_cmd_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload holds while stalled; no reset needed
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_command_ff <= rsp_command_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_command = rsp_command_ff;

endmodule
`default_nettype wire

### rtl/nec_ir_checker.sv
// Port-level checks for the NEC IR edge decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module nec_ir_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [1:0] rsp_status,
   input  wire logic [7:0] rsp_command
);
   import nec_ir_pkg::*;

   // a stalled result keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_command))

   // error results carry a zero command
   `ASSERT_IMPLY(a_err_cmd, clock, reset, rsp_valid && (rsp_status == ST_BIT_ERR || rsp_status == ST_INV_ERR), rsp_command == 8'd0)

   // an empty result register never blocks the edge channel
   `ASSERT_IMPLY(a_ready_free, clock, reset, !rsp_valid, req_ready)

   // a new result only follows an accepted edge
   `ASSERT_IMPLY(a_rsp_cause, clock, reset, rsp_valid && !$past(rsp_valid), $past(req_valid && req_ready))

   // a drained result with no transfer leaves the channel empty
   `ASSERT_NEXT(a_rsp_drain, clock, reset, rsp_valid && rsp_ready && !req_valid, !rsp_valid)

endmodule

bind nec_ir_edge_decoder_core nec_ir_checker u_nec_ir_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_status  (rsp_status),
   .rsp_command (rsp_command)
);
`default_nettype wire
